// ===== hdl/open_addressing_hash_table_assert.svh =====
// assertion macros for the hash table block
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define OAHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OAHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/oaht_pkg.sv =====
// shared types and constants of the hash table block
`default_nettype none

package oaht_pkg;

   localparam int KEY_W      = 31;
   localparam int CFG_W      = 9;
   localparam int PW         = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int SLOT_OUT_W = 8;
   localparam int STEP_BITS  = 4;
   localparam int DIV_STEPS  = 8;
   localparam int DIV_CNT_W  = 3;
   localparam int SIZE_MAX   = 511;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_SIZE = 2'd0,
      CSR_PROBE_MODE = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_HASH  = 4'b0100,
      S_PROBE = 4'b1000
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } slot_entry_type;

   typedef struct packed {
      logic          done;
      logic [PW-1:0] remainder;
   } hash_result_type;

endpackage

`default_nettype wire

// ===== hdl/oaht_mod_unit.sv =====
// iterative key modulo table size, four quotient bits per cycle
`default_nettype none

module oaht_mod_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [oaht_pkg::KEY_W-1:0] dividend,
   input  wire logic [oaht_pkg::PW-1:0]    divisor,
   output oaht_pkg::hash_result_type    result
);
   import oaht_pkg::*;

   localparam int SHIFT_W = STEP_BITS * DIV_STEPS;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [PW-1:0]        rem_ff, rem_in;
   logic [PW-1:0]        div_ff, div_in;
   logic [PW-1:0]        rem_step;

   always_comb begin
      logic [PW-1:0] tmp;
      rem_step = rem_ff;
      for (int b = 0; b < STEP_BITS; b++) begin
         tmp = {rem_step[PW-2:0], shift_ff[SHIFT_W-1-b]};
         rem_step = (tmp >= div_ff) ? tmp - div_ff : tmp;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = SHIFT_W'(dividend);
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = rem_step;
         shift_in = shift_ff << STEP_BITS;
         cnt_in   = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hdl/oaht_slot_mem.sv =====
// slot store: one write port, one read port with registered data
`default_nettype none

module oaht_slot_mem #(
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  oaht_pkg::slot_entry_type      wr_data,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output oaht_pkg::slot_entry_type      rd_data
);
   import oaht_pkg::*;

   slot_entry_type mem [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/open_addressing_hash_table.sv =====
// top level of the open-addressing hash table with linear or quadratic probing
//
// Request channel (req_valid/req_ready) carries one transaction: an operation
// (insert or search) and a 31-bit key. Response channel (rsp_valid/rsp_ready)
// returns one transaction per request: a status and the slot index.
// Configuration writes (csr_write_enable, csr_index, csr_write_data) set the
// table size and the probe mode and belong only where no transaction is in flight.
// The home slot is the key modulo the size, four bits per cycle in the
// remainder unit; each probed slot then goes through the registered slot
// memory read, and the result is loaded into the response register. A
// transaction takes from one probe up to as many as the table size. One
// request is worked at a time; req_ready returns once the previous one
// reaches the response register, so no new request is taken before then.
// After reset the block sweeps the slot memory to mark every slot empty, with
// req_ready low. A stalled response holds in the response register; a
// finished probe waits for that register to free up.
`default_nettype none

module open_addressing_hash_table #(
   parameter int TABLE_SLOTS = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output wire logic                          req_ready,
   input  wire logic                          req_operation,
   input  wire logic [oaht_pkg::KEY_W-1:0]    req_key,
   output wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output wire logic [1:0]                    rsp_status,
   output wire logic [oaht_pkg::SLOT_OUT_W-1:0] rsp_slot_index,
   input  wire logic                          csr_write_enable,
   input  wire logic [oaht_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [oaht_pkg::CFG_W-1:0]    csr_write_data
);
   import oaht_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam logic [PW-1:0] SIZE_CAP =
      (TABLE_SLOTS > SIZE_MAX) ? PW'(SIZE_MAX) : PW'(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(TABLE_SLOTS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CFG_W-1:0] table_size_ff;
   logic             probe_mode_ff;
   op_type           op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [PW-1:0]    size_ff, size_in;
   logic [PW-1:0]    s_ff, s_in;
   logic [PW-1:0]    d_ff, d_in;
   logic [PW-1:0]    cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic [PW-1:0]    size_now, size_raw;
   logic [PW-1:0]    sum, s_next, d_plus, d_next;
   logic             req_fire, out_free, rsp_load;
   logic             slot_empty, key_hit, last_probe, finish;
   hash_result_type  hash;
   logic             mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
   slot_entry_type   mem_wr_data, mem_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= CFG_W'(256);
         probe_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TABLE_SIZE: table_size_ff <= csr_write_data;
            CSR_PROBE_MODE: probe_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // active size: zero acts as one, capped at the slot count and at SIZE_MAX
   always_comb begin
      size_raw = (table_size_ff == '0) ? PW'(1) : PW'(table_size_ff);
      size_now = (size_raw > SIZE_CAP) ? SIZE_CAP : size_raw;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   oaht_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .dividend (req_key),
      .divisor  (size_now),
      .result   (hash)
   );

   // next probe slot, offsets advance by 1 or by odd steps for i*i
   always_comb begin
      sum    = s_ff + d_ff;
      s_next = (sum >= size_ff) ? sum - size_ff : sum;
      d_plus = d_ff + PW'(2);
      if (probe_mode_ff) begin
         d_next = (d_plus >= size_ff) ? d_plus - size_ff : d_plus;
      end else begin
         d_next = d_ff;
      end
   end

   assign slot_empty = !mem_rd_data.valid;
   assign key_hit    = mem_rd_data.valid && (mem_rd_data.key == key_ff);
   assign last_probe = (cnt_ff == size_ff - PW'(1));
   assign finish     = slot_empty || (op_ff == OP_SEARCH && key_hit) || last_probe;

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      size_in       = size_ff;
      s_in          = s_ff;
      d_in          = d_ff;
      cnt_in        = cnt_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = IDX_W'(s_ff);
      mem_wr_data   = '{valid: 1'b1, key: key_ff};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = IDX_W'(s_next);
      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '{valid: 1'b0, key: '0};
            clr_cnt_in  = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in    = op_type'(req_operation);
               key_in   = req_key;
               size_in  = size_now;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash.done) begin
               s_in        = hash.remainder;
               d_in        = PW'(1);
               cnt_in      = '0;
               mem_rd_en   = 1'b1;
               mem_rd_addr = IDX_W'(hash.remainder);
               state_in    = S_PROBE;
            end
         end
         S_PROBE: begin
            if (finish) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
                  if (op_ff == OP_INSERT) begin
                     if (slot_empty) begin
                        mem_wr_en     = 1'b1;
                        rsp_status_in = ST_INSERTED;
                        rsp_slot_in   = SLOT_OUT_W'(s_ff);
                     end else begin
                        rsp_status_in = ST_FULL;
                        rsp_slot_in   = '0;
                     end
                  end else begin
                     if (key_hit) begin
                        rsp_status_in = ST_FOUND;
                        rsp_slot_in   = SLOT_OUT_W'(s_ff);
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                        rsp_slot_in   = '0;
                     end
                  end
               end
            end else begin
               s_in      = s_next;
               d_in      = d_next;
               cnt_in    = cnt_ff + PW'(1);
               mem_rd_en = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      size_ff       <= size_in;
      s_ff          <= s_in;
      d_ff          <= d_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   oaht_slot_mem #(
      .DEPTH (TABLE_SLOTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

`include "open_addressing_hash_table_assert.svh"

   `OAHT_ASSERT_NOW(a_hash_done_in_hash, clock, reset, hash.done,
      state_ff == S_HASH, "remainder done outside hash state")
   `OAHT_ASSERT_NOW(a_probe_in_range, clock, reset, state_ff == S_PROBE,
      cnt_ff < size_ff && s_ff < size_ff, "probe beyond active size")
   `OAHT_ASSERT_NOW(a_write_owner, clock, reset, mem_wr_en,
      state_ff == S_CLEAR || (state_ff == S_PROBE && op_ff == OP_INSERT),
      "slot write outside clear or insert")
   `OAHT_ASSERT_NEXT(a_load_sets_valid, clock, reset, rsp_load,
      rsp_valid_ff && state_ff == S_IDLE, "finished transaction not presented")

endmodule

`default_nettype wire
